@@ rtl/core/vafc_pkg.sv @@
// Types and constants for the vendor action frame classifier.
// Used by the tracker, verdict and top-level modules; no dependencies.
package vafc_pkg;

  typedef enum logic [0:0] {
    REG_CAPTURE_ENABLE = 1'b0,
    REG_RADIO_CHANNEL  = 1'b1
  } cfg_reg_t;

  localparam logic [15:0] HDR_LEN     = 16'd30;
  localparam logic [15:0] PAYLOAD_SEQ = 16'd31;
  localparam logic [15:0] POS_MAX     = 16'hFFFF;
  localparam logic [7:0]  KIND_CHAT   = 8'h01;
  localparam logic [7:0]  KIND_VOICE  = 8'h02;

  typedef struct packed {
    logic       check;
    logic [7:0] want;
  } hdr_chk_t;

  typedef struct packed {
    logic        header_ok;
    logic [47:0] dst;
    logic [47:0] src;
    logic [7:0]  first;
    logic [7:0]  second;
    logic [15:0] len;
  } frame_sum_t;

  // Fixed header bytes: action frame, vendor category, OUI, type.
  function automatic hdr_chk_t expected_at(input logic [15:0] pos);
    hdr_chk_t r;
    r.check = 1'b1;
    case (pos)
      16'd0:   r.want = 8'hD0;
      16'd24:  r.want = 8'h7F;
      16'd25:  r.want = 8'h18;
      16'd26:  r.want = 8'hFE;
      16'd27:  r.want = 8'h34;
      16'd28:  r.want = 8'h04;
      default: begin
        r.check = 1'b0;
        r.want  = 8'h00;
      end
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/vafc_frame_track.sv @@
// Per-frame tracker: byte position, header match, address and payload capture.
// Depends on vafc_pkg.
module vafc_frame_track (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic [7:0]            data,
  input  logic                  last,
  output vafc_pkg::frame_sum_t  sum
);

  logic [15:0] pos;
  logic        header_ok;
  logic [47:0] dst;
  logic [47:0] src;
  logic [7:0]  first;
  logic [7:0]  second;

  vafc_pkg::hdr_chk_t chk;

  always_comb begin
    chk           = vafc_pkg::expected_at(pos);
    sum.header_ok = header_ok & ~(chk.check & (data != chk.want));
    sum.dst       = (pos >= 16'd4 && pos <= 16'd9) ? {dst[39:0], data} : dst;
    sum.src       = (pos >= 16'd10 && pos <= 16'd15) ? {src[39:0], data} : src;
    sum.first     = (pos == vafc_pkg::HDR_LEN) ? data : first;
    sum.second    = (pos == vafc_pkg::PAYLOAD_SEQ) ? data : second;
    sum.len       = (pos == vafc_pkg::POS_MAX) ? vafc_pkg::POS_MAX : pos + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      header_ok <= 1'b1;
      dst       <= '0;
      src       <= '0;
      first     <= '0;
      second    <= '0;
    end else if (advance) begin
      if (last) begin
        pos       <= '0;
        header_ok <= 1'b1;
        dst       <= '0;
        src       <= '0;
        first     <= '0;
        second    <= '0;
      end else begin
        pos       <= sum.len;
        header_ok <= sum.header_ok;
        dst       <= sum.dst;
        src       <= sum.src;
        first     <= sum.first;
        second    <= sum.second;
      end
    end
  end

endmodule

@@ rtl/core/vafc_verdict.sv @@
// Verdict and result register: accept decision, ring head/count, total counter.
// Depends on vafc_pkg.
module vafc_verdict #(
  parameter int RING_ENTRIES = 64,
  parameter int RAW_LIMIT    = 300,
  parameter int SLOT_W       = (RING_ENTRIES > 1) ? $clog2(RING_ENTRIES) : 1,
  parameter int COUNT_W      = $clog2(RING_ENTRIES + 1),
  parameter int LEN_W        = $clog2(RAW_LIMIT + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  vafc_pkg::frame_sum_t sum,
  input  logic                 mgmt,
  input  logic signed [7:0]    rssi,
  input  logic                 capture_enable,
  input  logic [3:0]           radio_channel,
  input  logic                 result_stall,
  output logic                 result_valid,
  output logic                 accepted,
  output logic [47:0]          source_mac,
  output logic [47:0]          dest_mac,
  output logic [LEN_W-1:0]     stored_length,
  output logic [1:0]           payload_kind,
  output logic [7:0]           payload_seq,
  output logic [3:0]           channel_out,
  output logic signed [7:0]    rssi_out,
  output logic [SLOT_W-1:0]    ring_slot,
  output logic [COUNT_W-1:0]   held_count,
  output logic [31:0]          total_frames
);

  logic [SLOT_W-1:0]  head;
  logic [SLOT_W-1:0]  head_next;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic [31:0]        total;
  logic [31:0]        total_next;
  logic               ok;
  logic [LEN_W-1:0]   stored;
  logic [1:0]         kind;
  logic [7:0]         seq;

  always_comb begin
    ok = capture_enable & mgmt & sum.header_ok & (sum.len >= vafc_pkg::HDR_LEN);
    stored = (sum.len >= 16'(RAW_LIMIT)) ? LEN_W'(RAW_LIMIT) : sum.len[LEN_W-1:0];
    kind = 2'd0;
    if (sum.len > vafc_pkg::HDR_LEN) begin
      if (sum.first == vafc_pkg::KIND_CHAT) kind = 2'd1;
      else if (sum.first == vafc_pkg::KIND_VOICE) kind = 2'd2;
    end
    seq = (sum.len > vafc_pkg::PAYLOAD_SEQ && kind != 2'd0) ? sum.second : 8'd0;
    head_next  = (head == SLOT_W'(RING_ENTRIES - 1)) ? '0 : head + 1'b1;
    count_next = (count < COUNT_W'(RING_ENTRIES)) ? count + 1'b1 : count;
    total_next = total + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head         <= '0;
      count        <= '0;
      total        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (fire) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (fire && ok) begin
        head  <= head_next;
        count <= count_next;
        total <= total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      accepted      <= ok;
      source_mac    <= ok ? sum.src : '0;
      dest_mac      <= ok ? sum.dst : '0;
      stored_length <= ok ? stored : '0;
      payload_kind  <= ok ? kind : '0;
      payload_seq   <= ok ? seq : '0;
      channel_out   <= ok ? radio_channel : '0;
      rssi_out      <= ok ? rssi : '0;
      ring_slot     <= ok ? head : '0;
      held_count    <= ok ? count_next : '0;
      total_frames  <= ok ? total_next : '0;
    end
  end

endmodule

@@ rtl/core/vendor_action_frame_classifier.sv @@
// Top level of the vendor action frame classifier: input register, config
// registers, frame tracker and verdict stage. Depends on vafc_pkg and submodules.
//
//   channel   handshake                   payload
//   frame     frame_valid / frame_stall   frame_byte frame_end mgmt_class signal_level
//   result    result_valid / result_stall accepted .. total_frames
//   config    cfg_we                      cfg_index cfg_data
//
// One byte request per cycle unless a final byte waits on a stalled result. A byte
// is held in the input register; the verdict register holds the result.
// Only a final byte waits on a stalled result; other bytes keep flowing.
// Reset is synchronous; it clears control state and counters, disables capture and sets the radio channel to 1.
module vendor_action_frame_classifier #(
  parameter int RING_ENTRIES = 64,
  parameter int RAW_LIMIT    = 300,
  parameter int SLOT_W       = (RING_ENTRIES > 1) ? $clog2(RING_ENTRIES) : 1,
  parameter int COUNT_W      = $clog2(RING_ENTRIES + 1),
  parameter int LEN_W        = $clog2(RAW_LIMIT + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [3:0]          cfg_data,
  input  logic                frame_valid,
  output logic                frame_stall,
  input  logic [7:0]          frame_byte,
  input  logic                frame_end,
  input  logic                mgmt_class,
  input  logic signed [7:0]   signal_level,
  output logic                result_valid,
  input  logic                result_stall,
  output logic                accepted,
  output logic [47:0]         source_mac,
  output logic [47:0]         dest_mac,
  output logic [LEN_W-1:0]    stored_length,
  output logic [1:0]          payload_kind,
  output logic [7:0]          payload_seq,
  output logic [3:0]          channel_out,
  output logic signed [7:0]   rssi_out,
  output logic [SLOT_W-1:0]   ring_slot,
  output logic [COUNT_W-1:0]  held_count,
  output logic [31:0]         total_frames
);

  logic                 capture_enable;
  logic [3:0]           radio_channel;
  logic                 s1_valid;
  logic [7:0]           s1_byte;
  logic                 s1_end;
  logic                 s1_mgmt;
  logic signed [7:0]    s1_rssi;
  logic                 go;
  logic                 load;
  vafc_pkg::frame_sum_t sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_enable <= 1'b0;
      radio_channel  <= 4'd1;
    end else if (cfg_we) begin
      case (vafc_pkg::cfg_reg_t'(cfg_index))
        vafc_pkg::REG_CAPTURE_ENABLE: capture_enable <= cfg_data[0];
        vafc_pkg::REG_RADIO_CHANNEL:  radio_channel  <= cfg_data;
        default: ;
      endcase
    end
  end

  // final byte needs room in the result register
  assign go          = s1_valid & (~s1_end | ~result_valid | ~result_stall);
  assign frame_stall = s1_valid & ~go;
  assign load        = frame_valid & ~frame_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= 1'b1;
    end else if (go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_byte <= frame_byte;
      s1_end  <= frame_end;
      s1_mgmt <= mgmt_class;
      s1_rssi <= signal_level;
    end
  end

  vafc_frame_track u_track (
    .clk     (clk),
    .rst     (rst),
    .advance (go),
    .data    (s1_byte),
    .last    (s1_end),
    .sum     (sum)
  );

  vafc_verdict #(
    .RING_ENTRIES (RING_ENTRIES),
    .RAW_LIMIT    (RAW_LIMIT),
    .SLOT_W       (SLOT_W),
    .COUNT_W      (COUNT_W),
    .LEN_W        (LEN_W)
  ) u_verdict (
    .clk            (clk),
    .rst            (rst),
    .fire           (go & s1_end),
    .sum            (sum),
    .mgmt           (s1_mgmt),
    .rssi           (s1_rssi),
    .capture_enable (capture_enable),
    .radio_channel  (radio_channel),
    .result_stall   (result_stall),
    .result_valid   (result_valid),
    .accepted       (accepted),
    .source_mac     (source_mac),
    .dest_mac       (dest_mac),
    .stored_length  (stored_length),
    .payload_kind   (payload_kind),
    .payload_seq    (payload_seq),
    .channel_out    (channel_out),
    .rssi_out       (rssi_out),
    .ring_slot      (ring_slot),
    .held_count     (held_count),
    .total_frames   (total_frames)
  );

endmodule

@@ rtl/core/vafc_checker.sv @@
// Port-level checks for the vendor action frame classifier, bound to the top.
// Depends on vendor_action_frame_classifier.
module vafc_checker #(
  parameter int RING_ENTRIES = 64,
  parameter int RAW_LIMIT    = 300,
  parameter int COUNT_W      = $clog2(RING_ENTRIES + 1),
  parameter int LEN_W        = $clog2(RAW_LIMIT + 1)
) (
  input logic               clk,
  input logic               rst,
  input logic               result_valid,
  input logic               result_stall,
  input logic               accepted,
  input logic [47:0]        source_mac,
  input logic [47:0]        dest_mac,
  input logic [LEN_W-1:0]   stored_length,
  input logic [1:0]         payload_kind,
  input logic [COUNT_W-1:0] held_count,
  input logic [31:0]        total_frames
);

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !accepted |-> source_mac == '0 && dest_mac == '0 &&
      stored_length == '0 && held_count == '0 && total_frames == '0)
    else $error("rejected frame carries nonzero fields");

  a_accept_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && accepted |-> stored_length >= LEN_W'(30) && held_count != '0 &&
      held_count <= COUNT_W'(RING_ENTRIES) && payload_kind != 2'd3)
    else $error("accepted frame fields out of range");

  a_total_step: assert property (@(posedge clk) disable iff (rst)
    result_valid && accepted && !result_stall ##1 result_valid && accepted
      |-> total_frames != $past(total_frames))
    else $error("total did not advance between accepted frames");

endmodule

bind vendor_action_frame_classifier vafc_checker #(
  .RING_ENTRIES (RING_ENTRIES),
  .RAW_LIMIT    (RAW_LIMIT),
  .COUNT_W      (COUNT_W),
  .LEN_W        (LEN_W)
) u_vafc_checker (
  .clk           (clk),
  .rst           (rst),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .accepted      (accepted),
  .source_mac    (source_mac),
  .dest_mac      (dest_mac),
  .stored_length (stored_length),
  .payload_kind  (payload_kind),
  .held_count    (held_count),
  .total_frames  (total_frames)
);
